@@ sv/accel_step_generator_sequencer_defines.svh @@
// Assertion macros used by the checker file.
// Depends on nothing; include guard below.
`ifndef ACCEL_STEP_GENERATOR_SEQUENCER_DEFINES_SVH
`define ACCEL_STEP_GENERATOR_SEQUENCER_DEFINES_SVH
// assert that a implies b on the same edge, reset gated
`define ASG_ASSERT_IMP(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);
// assert that a implies b on the next edge, reset gated
`define ASG_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);
`endif

@@ sv/asg_pkg.sv @@
// Package for the step generator: kind and command codes, fixed widths.
// No dependencies.
package asg_pkg;
    localparam int unsigned POS_W = 48;
    localparam logic [31:0] PERIOD_RESET = 32'd4294967;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_START = 2'd1,
        KIND_TICK  = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        CMD_EMPTY  = 3'd0,
        CMD_MOVE   = 3'd1,
        CMD_HEAT_E = 3'd2,
        CMD_HEAT_B = 3'd3,
        CMD_WAIT_E = 3'd4,
        CMD_WAIT_B = 3'd5,
        CMD_HOME_Z = 3'd6,
        CMD_RSVD   = 3'd7
    } t_cmd;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  axis;
        logic [31:0] target_steps;
        logic [31:0] start_speed;
        logic [31:0] accel;
        logic [2:0]  command_type;
        logic [9:0]  temp_setpoint;
        logic [9:0]  extruder_temp;
        logic [9:0]  bed_temp;
        logic        z1_at_limit;
        logic        z2_at_limit;
    } t_in_word;

    typedef struct packed {
        logic [1:0] step_x;
        logic [1:0] step_y;
        logic [1:0] step_z;
        logic [1:0] step_e;
        logic       step_z1;
        logic       step_z2;
        logic       set_extruder;
        logic       set_bed;
        logic [9:0] setpoint_out;
        logic       done_res;
    } t_out_word;
endpackage

@@ sv/asg_if.sv @@
// Valid/ready channel interfaces for the step generator input and result words.
// Depends on asg_pkg.
interface asg_in_if;
    logic              valid;
    logic              ready;
    asg_pkg::t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface asg_out_if;
    logic               valid;
    logic               ready;
    asg_pkg::t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/accel_step_generator_sequencer.sv @@
// One word in flight. Load, start and non-moving ticks go from accept straight to the result;
// a move tick runs S_SCAN, S_VMUL, S_VWAIT, S_PMUL and S_POS for each unfinished axis,
// skipping finished axes in S_SCAN; a homing tick that moves runs S_SCAN, S_PMUL, S_POS.
// One shared registered 32x33 multiplier (value times tick period) serves all axes.
// Reset (synchronous, active low) clears all axis state, done marks to one, period to default.
// Depends on asg_pkg and asg_if.
module accel_step_generator_sequencer #(
    parameter int NUM_AXES      = 4,
    parameter int FRACTION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    asg_in_if.sink      in_ch,
    asg_out_if.source   out_ch
);
    localparam int AX_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
    localparam int PW   = asg_pkg::POS_W;
    localparam logic signed [PW-1:0] POS_MAX = {1'b0, {(PW-1){1'b1}}};
    localparam logic signed [PW-1:0] POS_MIN = {1'b1, {(PW-1){1'b0}}};
    localparam logic signed [PW+1:0] HALF = (PW+2)'(1) <<< (FRACTION_BITS - 1);
    localparam logic [AX_W-1:0] LAST_AX = AX_W'(NUM_AXES - 1);
    localparam logic [AX_W-1:0] Z_AX = AX_W'(2);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_VMUL  = 7'b0000100,
        S_VWAIT = 7'b0001000,
        S_PMUL  = 7'b0010000,
        S_POS   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [31:0] r_period;
    logic signed [31:0] r_target [NUM_AXES];
    logic signed [31:0] r_accel  [NUM_AXES];
    logic signed [31:0] r_sspeed [NUM_AXES];
    logic signed [31:0] r_vel    [NUM_AXES];
    logic signed [PW-1:0] r_fine [NUM_AXES];
    logic signed [31:0] r_spos   [NUM_AXES];
    logic signed [1:0]  r_dir    [NUM_AXES];
    logic [NUM_AXES-1:0] r_adone;
    logic [1:0]  r_hdone;
    logic [2:0]  r_cmd;
    logic [9:0]  r_setp;
    logic [AX_W-1:0] r_ax;
    logic        r_home;
    logic        r_z1, r_z2;
    logic signed [63:0] r_prod;
    asg_pkg::t_out_word r_res;
    logic        r_ovalid;

    assign in_ch.ready   = (r_state == S_IDLE) && !r_ovalid;
    assign out_ch.valid  = r_ovalid;
    assign out_ch.data   = r_res;

    // shared multiplier operand and rounded product
    // scan multiplies the acceleration, the wait state the updated speed
    logic signed [31:0] w_opnd;
    logic signed [65:0] w_rnd;
    logic signed [33:0] w_inc;
    always_comb begin
        w_opnd = (r_state == S_SCAN && !r_home) ? r_accel[r_ax] : r_vel[r_ax];
        w_rnd  = 66'(r_prod) + (66'sd1 <<< 31);
        w_inc  = w_rnd[65:32];
    end

    // velocity update and fine position update candidates
    logic signed [33:0] w_v;
    logic signed [31:0] w_vsat;
    logic signed [PW+1:0] w_p, w_diff;
    logic signed [PW-1:0] w_psat;
    logic w_step;
    always_comb begin
        w_v = 34'(r_vel[r_ax]) + w_inc;
        if (w_v > 34'sd2147483647) w_vsat = 32'sh7fffffff;
        else if (w_v < -34'sd2147483648) w_vsat = 32'sh80000000;
        else w_vsat = w_v[31:0];
        w_p = (PW+2)'(r_fine[r_ax]) + (PW+2)'(w_inc);
        if (w_p > (PW+2)'(POS_MAX)) w_psat = POS_MAX;
        else if (w_p < (PW+2)'(POS_MIN)) w_psat = POS_MIN;
        else w_psat = w_p[PW-1:0];
        w_diff = (PW+2)'(r_fine[r_ax]) - ((PW+2)'(r_spos[r_ax]) <<< FRACTION_BITS);
        w_step = (w_diff >= HALF) || (w_diff <= -HALF);
    end

    logic w_alldone;
    assign w_alldone = (&r_adone) && (r_hdone == 2'b11);

    // homing tick that has to move Z
    logic w_home_go;
    assign w_home_go = (r_cmd == asg_pkg::CMD_HOME_Z)
                       && !(in_ch.data.z1_at_limit && in_ch.data.z2_at_limit)
                       && (NUM_AXES > 2);

    // result word for an accepted tick, before any stepping
    asg_pkg::t_out_word w_tick_res;
    always_comb begin
        w_tick_res = '0;
        case (r_cmd)
            asg_pkg::CMD_MOVE: w_tick_res.done_res = w_alldone;
            asg_pkg::CMD_HEAT_E: begin
                w_tick_res.set_extruder = 1'b1;
                w_tick_res.setpoint_out = r_setp;
                w_tick_res.done_res = 1'b1;
            end
            asg_pkg::CMD_HEAT_B: begin
                w_tick_res.set_bed = 1'b1;
                w_tick_res.setpoint_out = r_setp;
                w_tick_res.done_res = 1'b1;
            end
            asg_pkg::CMD_WAIT_E: begin
                w_tick_res.set_extruder = 1'b1;
                w_tick_res.setpoint_out = r_setp;
                w_tick_res.done_res = (&r_adone) && r_hdone[1] &&
                    (r_hdone[0] || r_setp < in_ch.data.extruder_temp);
            end
            asg_pkg::CMD_WAIT_B: begin
                w_tick_res.set_bed = 1'b1;
                w_tick_res.setpoint_out = r_setp;
                w_tick_res.done_res = (&r_adone) && r_hdone[0] &&
                    (r_hdone[1] || r_setp < in_ch.data.bed_temp);
            end
            asg_pkg::CMD_HOME_Z:
                w_tick_res.done_res = in_ch.data.z1_at_limit && in_ch.data.z2_at_limit;
            default: w_tick_res.done_res = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(w_opnd) * $signed({1'b0, r_period});
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_period <= asg_pkg::PERIOD_RESET;
            r_adone  <= '1;
            r_hdone  <= 2'b11;
            r_cmd    <= asg_pkg::CMD_EMPTY;
            r_setp   <= '0;
            r_ax     <= '0;
            r_home   <= 1'b0;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_target[a] <= '0; r_accel[a] <= '0; r_sspeed[a] <= '0;
                r_vel[a] <= '0; r_fine[a] <= '0; r_spos[a] <= '0; r_dir[a] <= '0;
            end
        end else begin
            if (i_cfg_we) r_period <= i_cfg_data;
            if (out_ch.valid && out_ch.ready) r_ovalid <= 1'b0;
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (in_ch.valid && in_ch.ready) begin
                        r_res <= (in_ch.data.kind == asg_pkg::KIND_TICK) ? w_tick_res : '0;
                        r_z1  <= in_ch.data.z1_at_limit;
                        r_z2  <= in_ch.data.z2_at_limit;
                        case (in_ch.data.kind)
                            asg_pkg::KIND_LOAD: begin
                                if (32'(in_ch.data.axis) < NUM_AXES) begin
                                    r_target[AX_W'(in_ch.data.axis)] <= in_ch.data.target_steps;
                                    r_sspeed[AX_W'(in_ch.data.axis)] <= in_ch.data.start_speed;
                                    r_accel[AX_W'(in_ch.data.axis)]  <= in_ch.data.accel;
                                end
                            end
                            asg_pkg::KIND_START: begin
                                r_cmd  <= in_ch.data.command_type;
                                r_setp <= in_ch.data.temp_setpoint;
                                r_hdone <= {in_ch.data.command_type != asg_pkg::CMD_WAIT_B,
                                            in_ch.data.command_type != asg_pkg::CMD_WAIT_E};
                                for (int a = 0; a < NUM_AXES; a++) begin
                                    r_vel[a]  <= r_sspeed[a];
                                    r_fine[a] <= '0;
                                    r_spos[a] <= '0;
                                    r_dir[a]  <= (r_target[a] > 0) ? 2'sd1 :
                                                 ((r_target[a] < 0) ? -2'sd1 : 2'sd0);
                                    r_adone[a] <= (r_target[a] == 0);
                                end
                            end
                            asg_pkg::KIND_TICK: begin
                                if (w_home_go) begin
                                    r_ax   <= Z_AX;
                                    r_home <= 1'b1;
                                end else begin
                                    r_ax   <= '0;
                                    r_home <= 1'b0;
                                end
                                case (r_cmd)
                                    asg_pkg::CMD_WAIT_E: begin
                                        if (r_setp < in_ch.data.extruder_temp) r_hdone[0] <= 1'b1;
                                    end
                                    asg_pkg::CMD_WAIT_B: begin
                                        if (r_setp < in_ch.data.bed_temp) r_hdone[1] <= 1'b1;
                                    end
                                    default: ;
                                endcase
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN: begin
                    // skip over done axes
                    if (!r_home && r_adone[r_ax] && r_ax != LAST_AX)
                        r_ax <= r_ax + AX_W'(1);
                end
                S_VMUL: r_vel[r_ax] <= w_vsat;
                S_VWAIT: ;
                S_PMUL: r_fine[r_ax] <= w_psat;
                S_POS: begin
                    // step decision from the updated fine position
                    if (r_home) begin
                        if (w_step) begin
                            r_spos[r_ax] <= r_spos[r_ax] + 32'sd1;
                            r_res.step_z1 <= !r_z1;
                            r_res.step_z2 <= !r_z2;
                        end
                    end else begin
                        if (w_step) begin
                            r_spos[r_ax] <= r_spos[r_ax] + 32'(r_dir[r_ax]);
                            case (r_ax)
                                AX_W'(0): r_res.step_x <= r_dir[r_ax];
                                AX_W'(1): r_res.step_y <= r_dir[r_ax];
                                AX_W'(2): r_res.step_z <= r_dir[r_ax];
                                AX_W'(3): r_res.step_e <= r_dir[r_ax];
                                default: ;
                            endcase
                        end
                        if ((w_step ? r_spos[r_ax] + 32'(r_dir[r_ax]) : r_spos[r_ax])
                                == r_target[r_ax])
                            r_adone[r_ax] <= 1'b1;
                        if (r_ax != LAST_AX) r_ax <= r_ax + AX_W'(1);
                    end
                end
                S_OUT: r_ovalid <= 1'b1;
                default: ;
            endcase
        end
    end

    // sequence control
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_ch.valid && in_ch.ready) begin
                    if (in_ch.data.kind == asg_pkg::KIND_TICK && r_cmd == asg_pkg::CMD_MOVE
                            && !w_alldone)
                        n_state = S_SCAN;
                    else if (in_ch.data.kind == asg_pkg::KIND_TICK && w_home_go)
                        n_state = S_SCAN;
                    else
                        n_state = S_OUT;
                end
            end
            S_SCAN: begin
                if (r_home) n_state = S_PMUL;
                else if (!r_adone[r_ax]) n_state = S_VMUL;
                else if (r_ax == LAST_AX) n_state = S_OUT;
                else n_state = S_SCAN;
            end
            S_VMUL:  n_state = S_VWAIT;
            S_VWAIT: n_state = S_PMUL;
            S_PMUL:  n_state = S_POS;
            S_POS:   n_state = (r_home || r_ax == LAST_AX) ? S_OUT : S_SCAN;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end
endmodule

@@ sv/asg_checker.sv @@
// Port-level checker for the step generator, bound to the top level.
// Depends on asg_pkg, asg_if and the defines header.
`include "accel_step_generator_sequencer_defines.svh"
module asg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  step_x,
    input logic        set_e,
    input logic        set_b,
    input logic [9:0]  setp
);
    `ASG_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, out_valid, !in_ready, "ready while result pending")
    `ASG_ASSERT_NEXT(a_one_result, i_clk, i_rst_n, in_valid && in_ready, !out_valid, "result too early")
    `ASG_ASSERT_IMP(a_step_code, i_clk, i_rst_n, out_valid, step_x != 2'b10, "bad step code")
    `ASG_ASSERT_IMP(a_setp_zero, i_clk, i_rst_n, out_valid && !set_e && !set_b, setp == 10'd0, "setpoint without set")
    `ASG_ASSERT_NEXT(a_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid, "result dropped")
endmodule

bind accel_step_generator_sequencer asg_checker u_asg_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .step_x(out_ch.data.step_x), .set_e(out_ch.data.set_extruder),
    .set_b(out_ch.data.set_bed), .setp(out_ch.data.setpoint_out)
);
